@@ src/sgr_attribute_decoder_assert.svh @@
// Assertion macros shared by the SGR attribute decoder modules.
// Each macro expects a clock named aclk and an active-low reset aresetn in scope.
`ifndef SGR_ATTRIBUTE_DECODER_ASSERT_SVH
`define SGR_ATTRIBUTE_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SGR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sgr_pkg.sv @@
// Types and constants for the SGR attribute decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package sgr_pkg;

    localparam int CodeWidth  = 16;
    localparam int ColorWidth = 8;
    localparam int IntenWidth = 2;
    localparam int StyleWidth = 4;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 8;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] CFG_DEFAULT_FCOLOR    = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_DEFAULT_BCOLOR    = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_DEFAULT_INTENSITY = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_DEFAULT_STYLE     = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_SAVED_FCOLOR      = 3'd4;
    localparam logic [CfgIdxWidth-1:0] CFG_SAVED_BCOLOR      = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [ColorWidth-1:0] RST_DEFAULT_FCOLOR    = 8'd7;
    localparam logic [ColorWidth-1:0] RST_DEFAULT_BCOLOR    = 8'd0;
    localparam logic [IntenWidth-1:0] RST_DEFAULT_INTENSITY = 2'd1;
    localparam logic [StyleWidth-1:0] RST_DEFAULT_STYLE     = 4'd0;
    localparam logic [ColorWidth-1:0] RST_SAVED_FCOLOR      = 8'd7;
    localparam logic [ColorWidth-1:0] RST_SAVED_BCOLOR      = 8'd0;

    // Intensity codes.
    localparam logic [IntenWidth-1:0] INTEN_DIM    = 2'd0;
    localparam logic [IntenWidth-1:0] INTEN_NORMAL = 2'd1;
    localparam logic [IntenWidth-1:0] INTEN_BOLD   = 2'd2;
    localparam logic [IntenWidth-1:0] INTEN_ILLEGAL = 2'd3;

    // Selector codes that follow 38 or 48.
    localparam logic [CodeWidth-1:0] SEL_DIRECT  = 16'd2;
    localparam logic [CodeWidth-1:0] SEL_INDEXED = 16'd5;

    // Offset of the bright half of the sixteen-color palette.
    localparam logic [ColorWidth-1:0] BRIGHT_OFFSET = 8'h08;

    typedef enum logic [1:0] {
        PH_DEFAULT = 2'd0,
        PH_PREFIX  = 2'd1,
        PH_INDEXED = 2'd2
    } sgr_phase_t;

    // Operation of one parameter when decoded in the default phase.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_FG_SET,
        OP_BG_SET,
        OP_RESET,
        OP_BOLD,
        OP_DIM,
        OP_NORMAL,
        OP_ITALIC_ON,
        OP_ITALIC_OFF,
        OP_UNDER_ON,
        OP_UNDER_OFF,
        OP_BLINK_ON,
        OP_BLINK_OFF,
        OP_REV_ON,
        OP_REV_OFF,
        OP_CS_ACTIVE,
        OP_CS_IBM,
        OP_CS_IBM_META,
        OP_PFX_FG,
        OP_PFX_BG,
        OP_FG_SAVED,
        OP_BG_SAVED
    } sgr_op_t;

    // One classified item as it travels through the queue.
    typedef struct packed {
        sgr_op_t                 op;
        logic [ColorWidth-1:0]   color;      // color for OP_FG_SET / OP_BG_SET
        logic [ColorWidth-1:0]   code_byte;  // low byte of the code, for indexed color
        logic                    sel_direct;
        logic                    sel_indexed;
        logic                    first;
        logic                    private_marker;
    } sgr_cmd_t;

    typedef struct packed {
        logic [ColorWidth-1:0] default_fcolor;
        logic [ColorWidth-1:0] default_bcolor;
        logic [IntenWidth-1:0] default_intensity;
        logic [StyleWidth-1:0] default_style;
        logic [ColorWidth-1:0] saved_fcolor;
        logic [ColorWidth-1:0] saved_bcolor;
    } sgr_cfg_t;

endpackage

`default_nettype wire

@@ src/sgr_front.sv @@
// Front end: classifies one SGR parameter into an operation and operands.
// Depends on sgr_pkg.
`default_nettype none

module sgr_front (
    input  wire logic [sgr_pkg::CodeWidth-1:0] code,
    input  wire logic                          first,
    input  wire logic                          private_marker,
    output sgr_pkg::sgr_cmd_t                  cmd
);
    import sgr_pkg::*;

    always_comb begin
        cmd                = '0;
        cmd.op             = OP_NONE;
        cmd.code_byte      = code[ColorWidth-1:0];
        cmd.sel_direct     = (code == SEL_DIRECT);
        cmd.sel_indexed    = (code == SEL_INDEXED);
        cmd.first          = first;
        cmd.private_marker = private_marker;

        unique case (code) inside
            [16'd30:16'd37]: begin
                cmd.op    = OP_FG_SET;
                cmd.color = code[ColorWidth-1:0] - 8'd30;
            end
            [16'd90:16'd97]: begin
                cmd.op    = OP_FG_SET;
                cmd.color = code[ColorWidth-1:0] - 8'd90 + BRIGHT_OFFSET;
            end
            [16'd40:16'd47]: begin
                cmd.op    = OP_BG_SET;
                cmd.color = code[ColorWidth-1:0] - 8'd40;
            end
            [16'd100:16'd107]: begin
                cmd.op    = OP_BG_SET;
                cmd.color = code[ColorWidth-1:0] - 8'd100 + BRIGHT_OFFSET;
            end
            16'd0:           cmd.op = OP_RESET;
            16'd1:           cmd.op = OP_BOLD;
            16'd2:           cmd.op = OP_DIM;
            16'd3:           cmd.op = OP_ITALIC_ON;
            16'd4:           cmd.op = OP_UNDER_ON;
            16'd5:           cmd.op = OP_BLINK_ON;
            16'd7:           cmd.op = OP_REV_ON;
            16'd10:          cmd.op = OP_CS_ACTIVE;
            16'd11:          cmd.op = OP_CS_IBM;
            16'd12:          cmd.op = OP_CS_IBM_META;
            16'd21, 16'd22:  cmd.op = OP_NORMAL;
            16'd23:          cmd.op = OP_ITALIC_OFF;
            16'd24:          cmd.op = OP_UNDER_OFF;
            16'd25:          cmd.op = OP_BLINK_OFF;
            16'd27:          cmd.op = OP_REV_OFF;
            16'd38:          cmd.op = OP_PFX_FG;
            16'd39:          cmd.op = OP_FG_SAVED;
            16'd48:          cmd.op = OP_PFX_BG;
            16'd49:          cmd.op = OP_BG_SAVED;
            default:         cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

@@ src/sgr_fifo.sv @@
// Short command queue between the front end and the back end.
// Depends on sgr_pkg and sgr_attribute_decoder_assert.svh.
`default_nettype none
`include "sgr_attribute_decoder_assert.svh"

module sgr_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire sgr_pkg::sgr_cmd_t push_cmd,
    output logic                   full,
    input  wire logic              pop,
    output sgr_pkg::sgr_cmd_t      pop_cmd,
    output logic                   not_empty
);
    import sgr_pkg::*;

    localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
    localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

    sgr_cmd_t            slot_reg [DEPTH];
    logic [PtrWidth-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0] count_reg, count_next;

    assign full      = (count_reg == FullCnt);
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `SGR_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FullCnt, "queue count above depth")
    `SGR_ASSERT_NOW(a_empty_ptrs, count_reg == '0, rd_ptr_reg == wr_ptr_reg, "empty queue with split pointers")
    `SGR_ASSERT_NEXT(a_fill_step, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue fill lost an item")

endmodule

`default_nettype wire

@@ src/sgr_back.sv @@
// Back end: runs the parse machine, updates the attribute and holds the result.
// Depends on sgr_pkg and sgr_attribute_decoder_assert.svh.
`default_nettype none
`include "sgr_attribute_decoder_assert.svh"

module sgr_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sgr_pkg::sgr_cfg_t cfg,
    input  wire sgr_pkg::sgr_cmd_t cmd,
    input  wire logic              cmd_valid,
    output logic                   cmd_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata
);
    import sgr_pkg::*;

    sgr_phase_t            phase_reg, phase_next, phase_eff;
    logic                  tbg_reg, tbg_next, tbg_eff;
    logic [ColorWidth-1:0] fcolor_reg, fcolor_next;
    logic [ColorWidth-1:0] bcolor_reg, bcolor_next;
    logic [IntenWidth-1:0] inten_reg, inten_next;
    logic                  italic_reg, italic_next;
    logic                  under_reg, under_next;
    logic                  blink_reg, blink_next;
    logic                  rev_reg, rev_next;
    logic                  ibm_reg, ibm_next;
    logic                  ctrl_reg, ctrl_next;
    logic                  meta_reg, meta_next;
    logic                  direct_reg, direct_next;
    logic                  valid_reg, valid_next;
    logic                  live;
    logic [IntenWidth-1:0] default_inten;

    assign cmd_pop = cmd_valid && (!valid_reg || m_tready);
    assign live    = cmd_pop && !cmd.private_marker;

    // A first marker clears the parse state before the item is decoded.
    assign phase_eff = cmd.first ? PH_DEFAULT : phase_reg;
    assign tbg_eff   = cmd.first ? 1'b0 : tbg_reg;

    assign default_inten = (cfg.default_intensity == INTEN_ILLEGAL) ? INTEN_BOLD
                                                                    : cfg.default_intensity;

    // Parse machine: next state.
    always_comb begin
        phase_next = phase_reg;
        tbg_next   = tbg_reg;
        if (live) begin
            tbg_next = tbg_eff;
            unique case (phase_eff)
                PH_INDEXED: phase_next = PH_DEFAULT;
                PH_PREFIX: begin
                    if (cmd.sel_direct) begin
                        phase_next = PH_PREFIX;
                    end else if (cmd.sel_indexed) begin
                        phase_next = PH_INDEXED;
                    end else begin
                        phase_next = PH_DEFAULT;
                    end
                end
                default: begin
                    phase_next = PH_DEFAULT;
                    if (cmd.op == OP_PFX_FG) begin
                        phase_next = PH_PREFIX;
                        tbg_next   = 1'b0;
                    end else if (cmd.op == OP_PFX_BG) begin
                        phase_next = PH_PREFIX;
                        tbg_next   = 1'b1;
                    end
                end
            endcase
        end
    end

    // Parse machine: attribute and result updates.
    always_comb begin
        fcolor_next = fcolor_reg;
        bcolor_next = bcolor_reg;
        inten_next  = inten_reg;
        italic_next = italic_reg;
        under_next  = under_reg;
        blink_next  = blink_reg;
        rev_next    = rev_reg;
        ibm_next    = ibm_reg;
        ctrl_next   = ctrl_reg;
        meta_next   = meta_reg;
        direct_next = cmd_pop ? 1'b0 : direct_reg;
        if (live) begin
            unique case (phase_eff)
                PH_INDEXED: begin
                    if (tbg_eff) begin
                        bcolor_next = cmd.code_byte;
                    end else begin
                        fcolor_next = cmd.code_byte;
                    end
                end
                PH_PREFIX: direct_next = cmd.sel_direct;
                default: begin
                    unique case (cmd.op)
                        OP_FG_SET:      fcolor_next = cmd.color;
                        OP_BG_SET:      bcolor_next = cmd.color;
                        OP_RESET: begin
                            fcolor_next = cfg.default_fcolor;
                            bcolor_next = cfg.default_bcolor;
                            inten_next  = default_inten;
                            italic_next = cfg.default_style[0];
                            under_next  = cfg.default_style[1];
                            blink_next  = cfg.default_style[2];
                            rev_next    = cfg.default_style[3];
                        end
                        OP_BOLD:        inten_next  = INTEN_BOLD;
                        OP_DIM:         inten_next  = INTEN_DIM;
                        OP_NORMAL:      inten_next  = INTEN_NORMAL;
                        OP_ITALIC_ON:   italic_next = 1'b1;
                        OP_ITALIC_OFF:  italic_next = 1'b0;
                        OP_UNDER_ON:    under_next  = 1'b1;
                        OP_UNDER_OFF:   under_next  = 1'b0;
                        OP_BLINK_ON:    blink_next  = 1'b1;
                        OP_BLINK_OFF:   blink_next  = 1'b0;
                        OP_REV_ON:      rev_next    = 1'b1;
                        OP_REV_OFF:     rev_next    = 1'b0;
                        OP_CS_ACTIVE: begin
                            ibm_next  = 1'b0;
                            ctrl_next = 1'b0;
                            meta_next = 1'b0;
                        end
                        OP_CS_IBM: begin
                            ibm_next  = 1'b1;
                            ctrl_next = 1'b1;
                            meta_next = 1'b0;
                        end
                        OP_CS_IBM_META: begin
                            ibm_next  = 1'b1;
                            ctrl_next = 1'b1;
                            meta_next = 1'b1;
                        end
                        OP_FG_SAVED: begin
                            fcolor_next = cfg.saved_fcolor;
                            under_next  = 1'b0;
                        end
                        OP_BG_SAVED:    bcolor_next = cfg.saved_bcolor;
                        default: ;
                    endcase
                end
            endcase
        end
    end

    // Result register: load on pop, drop once taken.
    always_comb begin
        valid_next = valid_reg;
        if (cmd_pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_DEFAULT;
            tbg_reg    <= 1'b0;
            fcolor_reg <= RST_DEFAULT_FCOLOR;
            bcolor_reg <= RST_DEFAULT_BCOLOR;
            inten_reg  <= RST_DEFAULT_INTENSITY;
            italic_reg <= RST_DEFAULT_STYLE[0];
            under_reg  <= RST_DEFAULT_STYLE[1];
            blink_reg  <= RST_DEFAULT_STYLE[2];
            rev_reg    <= RST_DEFAULT_STYLE[3];
            ibm_reg    <= 1'b0;
            ctrl_reg   <= 1'b0;
            meta_reg   <= 1'b0;
            direct_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            tbg_reg    <= tbg_next;
            fcolor_reg <= fcolor_next;
            bcolor_reg <= bcolor_next;
            inten_reg  <= inten_next;
            italic_reg <= italic_next;
            under_reg  <= under_next;
            blink_reg  <= blink_next;
            rev_reg    <= rev_next;
            ibm_reg    <= ibm_next;
            ctrl_reg   <= ctrl_next;
            meta_reg   <= meta_next;
            direct_reg <= direct_next;
            valid_reg  <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, direct_reg, meta_reg, ctrl_reg, ibm_reg,
                       rev_reg, blink_reg, under_reg, italic_reg,
                       inten_reg, bcolor_reg, fcolor_reg};

    `SGR_ASSERT_NOW(a_direct_prefix, direct_reg, phase_reg == PH_PREFIX, "direct color outside prefix phase")
    `SGR_ASSERT_NOW(a_meta_ibm, meta_reg, ibm_reg && ctrl_reg, "meta toggle without IBM charset")
    `SGR_ASSERT_NOW(a_inten_range, 1'b1, inten_reg != INTEN_ILLEGAL, "intensity out of range")

endmodule

`default_nettype wire

@@ src/sgr_attribute_decoder.sv @@
// SGR attribute decoder: front classifier, command queue, back executor.
// Each accepted item is written into a queue slot, then popped and loaded into the result register.
// Throughput: one item per cycle while m_tready stays high; the back end updates the attribute as it pops each item.
// The result register is freed in the cycle it is taken, so input and output stall apart.
// Reset (aresetn low, synchronous): parse state cleared, attribute and configuration
// registers take their reset defaults, charset flags cleared, queue and result emptied.
`default_nettype none

module sgr_attribute_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] code
    input  wire logic [1:0]  s_tuser,   // [0] first, [1] private_marker
    // Result items.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] fcolor, [15:8] bcolor, [17:16] intensity, [18] italic, [19] underline,
    // [20] blink, [21] reverse, [22] ibm_charset, [23] show_controls,
    // [24] meta_toggle, [25] direct_color_seen, [31:26] zero
    output logic [31:0]      m_tdata,
    // Configuration writes.
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata
);
    import sgr_pkg::*;

    sgr_cfg_t cfg_reg;
    sgr_cmd_t front_cmd;
    sgr_cmd_t queue_cmd;
    logic     queue_full;
    logic     queue_valid;
    logic     queue_pop;
    logic     push;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.default_fcolor    <= RST_DEFAULT_FCOLOR;
            cfg_reg.default_bcolor    <= RST_DEFAULT_BCOLOR;
            cfg_reg.default_intensity <= RST_DEFAULT_INTENSITY;
            cfg_reg.default_style     <= RST_DEFAULT_STYLE;
            cfg_reg.saved_fcolor      <= RST_SAVED_FCOLOR;
            cfg_reg.saved_bcolor      <= RST_SAVED_BCOLOR;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DEFAULT_FCOLOR:    cfg_reg.default_fcolor    <= cfg_wdata;
                CFG_DEFAULT_BCOLOR:    cfg_reg.default_bcolor    <= cfg_wdata;
                CFG_DEFAULT_INTENSITY: cfg_reg.default_intensity <= cfg_wdata[IntenWidth-1:0];
                CFG_DEFAULT_STYLE:     cfg_reg.default_style     <= cfg_wdata[StyleWidth-1:0];
                CFG_SAVED_FCOLOR:      cfg_reg.saved_fcolor      <= cfg_wdata;
                CFG_SAVED_BCOLOR:      cfg_reg.saved_bcolor      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Accept while the queue has room; classify on the way in.
    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    sgr_front u_front (
        .code           (s_tdata),
        .first          (s_tuser[0]),
        .private_marker (s_tuser[1]),
        .cmd            (front_cmd)
    );

    sgr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_cmd   (queue_cmd),
        .not_empty (queue_valid)
    );

    // Execute in order; the result register sits at the back end's output.
    sgr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd       (queue_cmd),
        .cmd_valid (queue_valid),
        .cmd_pop   (queue_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
